### rtl/aho_pkg.sv
// Shared types and constants for the flat Aho-Corasick scanner.
`default_nettype none
package aho_pkg;

    localparam int STATE_W     = 10;
    localparam int SYMBOL_W    = 8;
    localparam int OFF_W       = 12;
    localparam int COUNT_W     = 5;
    localparam int IDX_W       = 12;
    localparam int IDV_W       = 16;
    localparam int POS_W       = 48;
    localparam int STATE_LIMIT = 1 << STATE_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        OP_TRANS = 2'd0,
        OP_OUTS  = 2'd1,
        OP_ID    = 2'd2,
        OP_SCAN  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [STATE_W-1:0]   state_index;
        logic [SYMBOL_W-1:0]  symbol;
        logic [STATE_W-1:0]   next_state;
        logic [OFF_W-1:0]     out_offset;
        logic [COUNT_W-1:0]   out_count;
        logic [IDX_W-1:0]     id_index;
        logic [IDV_W-1:0]     id_value;
        logic                 restart;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]     end_position;
        logic [IDV_W-1:0]     match_id;
        logic                 last;
    } t_out_item;

    // Work passed from front to back; state_index carries the new state for scans.
    typedef struct packed {
        t_op                  op;
        logic [STATE_W-1:0]   state_index;
        logic [OFF_W-1:0]     out_offset;
        logic [COUNT_W-1:0]   out_count;
        logic [IDX_W-1:0]     id_index;
        logic [IDV_W-1:0]     id_value;
        logic [POS_W-1:0]     pos;
    } t_q_item;

endpackage
`default_nettype wire

### rtl/aho_front.sv
// Front end: accepts transactions, owns the transition table and steps the automaton.
`default_nettype none
module aho_front
    import aho_pkg::*;
#(
    parameter int NUM_STATES = 1024,
    parameter int ALPHABET   = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_push,
    output t_q_item       o_q_item,
    input  wire logic     i_q_full
);

    localparam int NS_EFF = (NUM_STATES < STATE_LIMIT) ? NUM_STATES : STATE_LIMIT;
    localparam int SW     = $clog2(NS_EFF);
    localparam int SYM_W  = $clog2(ALPHABET);
    localparam int AW     = SW + SYM_W;
    localparam int TDEPTH = NS_EFF * (2 ** SYM_W);

    logic [STATE_W-1:0] r_tmem [TDEPTH];
    logic [STATE_W-1:0] r_tq;
    logic [STATE_W-1:0] r_state;
    logic [POS_W-1:0]   r_pos;
    logic               r_s1_valid;
    t_q_item            r_s1;
    logic               r_s1_oob;

    logic [STATE_W-1:0] w_ns;
    logic [STATE_W-1:0] w_state;
    logic [STATE_W-1:0] w_scan_state;
    logic [POS_W-1:0]   w_scan_pos;
    logic               w_free;
    logic               w_acc;
    logic               w_oob;
    logic               w_rd;
    logic               w_we;
    logic [AW-1:0]      w_raddr;
    logic [AW-1:0]      w_waddr;
    t_q_item            w_new;

    always_comb begin
        w_ns = (r_s1_oob || (32'(r_tq) >= 32'(NUM_STATES))) ? '0 : r_tq;
        w_state = (r_s1_valid && r_s1.op == OP_SCAN) ? w_ns : r_state;
        w_scan_state = i_item.restart ? '0 : w_state;
        w_scan_pos = i_item.restart ? '0 : r_pos;
        w_free = !r_s1_valid || !i_q_full;
        w_acc = i_valid && w_free;
        w_oob = 32'(i_item.symbol) >= 32'(ALPHABET);
        w_rd = w_acc && (i_item.op == OP_SCAN);
        w_we = w_acc && (i_item.op == OP_TRANS) && !w_oob
            && (32'(i_item.state_index) < 32'(NUM_STATES));
        w_raddr = {w_scan_state[SW-1:0], i_item.symbol[SYM_W-1:0]};
        w_waddr = {i_item.state_index[SW-1:0], i_item.symbol[SYM_W-1:0]};

        w_new.op          = i_item.op;
        w_new.state_index = i_item.state_index;
        w_new.out_offset  = i_item.out_offset;
        w_new.out_count   = i_item.out_count;
        w_new.id_index    = i_item.id_index;
        w_new.id_value    = i_item.id_value;
        w_new.pos         = w_scan_pos;

        o_q_item = r_s1;
        if (r_s1.op == OP_SCAN) begin
            o_q_item.state_index = w_ns;
        end
        o_push  = r_s1_valid && !i_q_full;
        o_stall = !w_free;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tmem[w_waddr] <= i_item.next_state;
        end
        if (w_rd) begin
            r_tq <= r_tmem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_item.op != OP_TRANS)) begin
            r_s1     <= w_new;
            r_s1_oob <= w_oob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_state    <= '0;
            r_pos      <= '0;
        end else begin
            if (r_s1_valid && r_s1.op == OP_SCAN) begin
                r_state <= w_ns;
            end
            if (o_push) begin
                r_s1_valid <= 1'b0;
            end
            if (w_acc) begin
                case (i_item.op)
                    OP_SCAN: begin
                        r_s1_valid <= 1'b1;
                        r_pos      <= w_scan_pos + 1'b1;
                    end
                    OP_OUTS, OP_ID: begin
                        r_s1_valid <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### rtl/aho_queue.sv
// Short FIFO between the front end and the match emitter.
`default_nettype none
module aho_queue
    import aho_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_q_item i_item,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_q_item      o_item
);

    t_q_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                w_wr;
    logic                w_rd;

    always_comb begin
        o_full  = r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH);
        o_valid = r_cnt != '0;
        o_item  = r_mem[r_rp];
        w_wr    = i_push && !o_full;
        w_rd    = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/aho_back.sv
// Back end: owns the output-run and pattern id tables and emits match results.
`default_nettype none
module aho_back
    import aho_pkg::*;
#(
    parameter int NUM_STATES     = 1024,
    parameter int ID_STORE_DEPTH = 4096,
    parameter int MAX_MATCHES    = 16,
    parameter int ID_WIDTH       = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    input  wire t_q_item i_q_item,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_out_item    o_item
);

    localparam int NS_EFF = (NUM_STATES < STATE_LIMIT) ? NUM_STATES : STATE_LIMIT;
    localparam int SW     = $clog2(NS_EFF);
    localparam int ID_AW  = (ID_STORE_DEPTH > 1) ? $clog2(ID_STORE_DEPTH) : 1;
    localparam int CW     = $clog2(MAX_MATCHES + 1);
    localparam int STEP_W = 1;
    localparam int OM_W   = OFF_W + COUNT_W;
    // offset mod depth: quotient by reciprocal multiply, remainder by subtract
    localparam int     RECIP_S = 24;
    localparam int     PROD_W  = OFF_W + RECIP_S + 1;
    localparam longint RECIP_M = ((longint'(1) << RECIP_S) / longint'(ID_STORE_DEPTH)) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RED,
        ST_LOOK,
        ST_DATA
    } t_state;

    logic [OM_W-1:0]     r_omem [NS_EFF];
    logic [OM_W-1:0]     r_oq;
    logic [ID_WIDTH-1:0] r_imem [ID_STORE_DEPTH];
    logic [ID_WIDTH-1:0] r_iq;

    t_state              r_st;
    logic [OFF_W-1:0]    r_red;
    logic [OFF_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_step;
    logic [SW-1:0]       r_widx;
    logic [COUNT_W-1:0]  r_wcnt;
    logic [POS_W-1:0]    r_pos;
    logic [ID_AW-1:0]    r_slot;
    logic [CW-1:0]       r_left;
    logic                r_o_valid;
    t_out_item           r_out;

    logic                      w_out_free;
    logic [PROD_W-1:0]         w_prod;
    logic [OFF_W-1:0]          w_quo;
    logic [31:0]               w_qd;
    logic [OFF_W-1:0]          w_red_next;
    logic                      w_owe;
    logic                      w_orde;
    logic                      w_iwe;
    logic                      w_irde;
    logic [ID_AW-1:0]          w_iaddr;
    logic [ID_AW+IDX_W-1:0]    w_widx_ext;
    logic [ID_WIDTH+IDV_W-1:0] w_idv_ext;
    logic [ID_AW+OFF_W-1:0]    w_base_ext;
    logic [ID_AW-1:0]          w_base;
    logic [CW+COUNT_W-1:0]     w_cnt_ext;
    logic [CW-1:0]             w_cnt;
    logic [IDV_W+ID_WIDTH-1:0] w_id_ext;

    function automatic logic [ID_AW-1:0] f_inc(input logic [ID_AW-1:0] s);
        return ((32'(s) + 32'd1) == 32'(ID_STORE_DEPTH)) ? '0 : ID_AW'(s + 1'b1);
    endfunction

    always_comb begin
        w_out_free = !r_o_valid || !i_stall;
        o_pop      = (r_st == ST_IDLE) && i_q_valid;

        w_prod     = PROD_W'(r_red) * PROD_W'(RECIP_M);
        w_quo      = w_prod[RECIP_S +: OFF_W];
        w_qd       = 32'(r_quo) * 32'(ID_STORE_DEPTH);
        w_red_next = r_red - w_qd[OFF_W-1:0];
        w_owe      = (r_st == ST_RED) && (r_step == '0);
        w_orde     = o_pop && (i_q_item.op == OP_SCAN);

        w_widx_ext = {ID_AW'(0), i_q_item.id_index};
        w_idv_ext  = {ID_WIDTH'(0), i_q_item.id_value};
        w_iwe      = o_pop && (i_q_item.op == OP_ID)
            && (32'(i_q_item.id_index) < 32'(ID_STORE_DEPTH));

        w_base_ext = {ID_AW'(0), r_oq[OM_W-1:COUNT_W]};
        w_base     = w_base_ext[ID_AW-1:0];
        w_cnt_ext  = {CW'(0), r_oq[COUNT_W-1:0]};
        if (32'(r_oq[COUNT_W-1:0]) > 32'(MAX_MATCHES)) begin
            w_cnt = CW'(MAX_MATCHES);
        end else begin
            w_cnt = w_cnt_ext[CW-1:0];
        end

        w_irde  = 1'b0;
        w_iaddr = r_slot;
        if (r_st == ST_LOOK && w_cnt != '0) begin
            w_irde  = 1'b1;
            w_iaddr = w_base;
        end else if (r_st == ST_DATA && w_out_free && r_left != CW'(1)) begin
            w_irde  = 1'b1;
        end

        w_id_ext = {IDV_W'(0), r_iq};
        o_valid  = r_o_valid;
        o_item   = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_owe) begin
            r_omem[r_widx] <= {w_red_next, r_wcnt};
        end
        if (w_orde) begin
            r_oq <= r_omem[i_q_item.state_index[SW-1:0]];
        end
        if (w_iwe) begin
            r_imem[w_widx_ext[ID_AW-1:0]] <= w_idv_ext[ID_WIDTH-1:0];
        end
        if (w_irde) begin
            r_iq <= r_imem[w_iaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_q_item.op)
                            OP_OUTS: begin
                                if (32'(i_q_item.state_index) < 32'(NUM_STATES)) begin
                                    r_red  <= i_q_item.out_offset;
                                    r_step <= 1'b1;
                                    r_widx <= i_q_item.state_index[SW-1:0];
                                    r_wcnt <= i_q_item.out_count;
                                    r_st   <= ST_RED;
                                end
                            end
                            OP_SCAN: begin
                                r_pos <= i_q_item.pos;
                                r_st  <= ST_LOOK;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RED: begin
                    if (r_step == '0) begin
                        r_st <= ST_IDLE;
                    end else begin
                        r_quo  <= w_quo;
                        r_step <= r_step - 1'b1;
                    end
                end
                ST_LOOK: begin
                    if (w_cnt == '0) begin
                        r_st <= ST_IDLE;
                    end else begin
                        r_slot <= f_inc(w_base);
                        r_left <= w_cnt;
                        r_st   <= ST_DATA;
                    end
                end
                ST_DATA: begin
                    if (w_out_free) begin
                        r_o_valid          <= 1'b1;
                        r_out.end_position <= r_pos;
                        r_out.match_id     <= w_id_ext[IDV_W-1:0];
                        r_out.last         <= r_left == CW'(1);
                        if (r_left == CW'(1)) begin
                            r_st <= ST_IDLE;
                        end else begin
                            r_slot <= f_inc(r_slot);
                            r_left <= r_left - 1'b1;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/aho_corasick_flat_scan.sv
// Top level of the flat Aho-Corasick multi-pattern scanner.
// A scan byte passes the front register and transition read, the queue, the output-run table read,
// the id table read and the output register; further matches follow 1/cycle unless i_stall holds.
// Throughput: front takes a transaction per cycle while the 4-entry queue has room; the back pops
// a new item only when idle; a state-output write passes the offset reduction before it is stored.
// Reset: synchronous; clears state, position, queue and output valid; tables are not cleared.
`default_nettype none
module aho_corasick_flat_scan
    import aho_pkg::*;
#(
    parameter int NUM_STATES     = 1024,
    parameter int ALPHABET       = 256,
    parameter int ID_STORE_DEPTH = 4096,
    parameter int MAX_MATCHES    = 16,
    parameter int ID_WIDTH       = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_item
);

    logic    w_push;
    t_q_item w_push_item;
    logic    w_q_full;
    logic    w_pop;
    logic    w_q_valid;
    t_q_item w_q_item;

    aho_front #(
        .NUM_STATES (NUM_STATES),
        .ALPHABET   (ALPHABET)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_push   (w_push),
        .o_q_item (w_push_item),
        .i_q_full (w_q_full)
    );

    aho_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    aho_back #(
        .NUM_STATES     (NUM_STATES),
        .ID_STORE_DEPTH (ID_STORE_DEPTH),
        .MAX_MATCHES    (MAX_MATCHES),
        .ID_WIDTH       (ID_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("push into full queue");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_q_full)
        else $error("front stalled with queue room");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the flat Aho-Corasick scanner: table loads, edge scans, random text.
module tb_top;
    import aho_pkg::*;

    localparam int MATCH_MAX  = 16;
    localparam int ITEMS      = 150;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 40;
    localparam int N_ST       = 8;
    localparam int N_COL      = 16;
    localparam int REPORT_MAX = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    aho_corasick_flat_scan dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    always #1 clk = ~clk;

    // Shadow copy of the automaton and scan position
    logic [STATE_W-1:0] next_tbl [0:(1 << (STATE_W + SYMBOL_W))-1];
    logic [OFF_W-1:0]   run_off  [0:STATE_LIMIT-1];
    logic [COUNT_W-1:0] run_len  [0:STATE_LIMIT-1];
    logic [IDV_W-1:0]   id_store [0:(1 << IDX_W)-1];
    logic [STATE_W-1:0] scan_state = '0;
    logic [POS_W-1:0]   scan_pos   = '0;
    t_out_item          pending_matches [$];

    // States and bytes the text walks through; every pair is loaded before scanning
    logic [STATE_W-1:0]  live_states [N_ST];
    logic [SYMBOL_W-1:0] live_syms   [N_COL];

    int burst_left  = 0;
    int rx_hold     = 0;
    int mismatches  = 0;
    int idle_cycles = 0;

    function automatic void track_item(input t_in_item it);
        logic [STATE_W-1:0] ns;
        logic [IDX_W-1:0]   slot;
        int                 cnt;
        t_out_item          m;
        case (it.op)
            OP_TRANS: next_tbl[{it.state_index, it.symbol}] = it.next_state;
            OP_OUTS: begin
                run_off[it.state_index] = it.out_offset;
                run_len[it.state_index] = it.out_count;
            end
            OP_ID: id_store[it.id_index] = it.id_value;
            default: begin
                if (it.restart) begin
                    scan_state = '0;
                    scan_pos   = '0;
                end
                ns         = next_tbl[{scan_state, it.symbol}];
                scan_state = ns;
                cnt = (run_len[ns] > MATCH_MAX) ? MATCH_MAX : int'(run_len[ns]);
                for (int k = 0; k < cnt; k++) begin
                    slot           = run_off[ns] + IDX_W'(k);
                    m.end_position = scan_pos;
                    m.match_id     = id_store[slot];
                    m.last         = (k == cnt - 1);
                    pending_matches.push_back(m);
                end
                scan_pos = scan_pos + 1'b1;
            end
        endcase
    endfunction

    function automatic t_in_item noise_item(input t_op op);
        logic [95:0] raw;
        t_in_item    it;
        raw   = {$urandom, $urandom, $urandom};
        it    = raw[$bits(t_in_item)-1:0];
        it.op = op;
        return it;
    endfunction

    function automatic t_in_item trans_item(input logic [STATE_W-1:0] s,
                                            input logic [SYMBOL_W-1:0] c,
                                            input logic [STATE_W-1:0] t);
        t_in_item it;
        it             = noise_item(OP_TRANS);
        it.state_index = s;
        it.symbol      = c;
        it.next_state  = t;
        return it;
    endfunction

    function automatic t_in_item outs_item(input logic [STATE_W-1:0] s,
                                           input logic [OFF_W-1:0] off,
                                           input logic [COUNT_W-1:0] cnt);
        t_in_item it;
        it             = noise_item(OP_OUTS);
        it.state_index = s;
        it.out_offset  = off;
        it.out_count   = cnt;
        return it;
    endfunction

    function automatic t_in_item id_item(input logic [IDX_W-1:0] idx,
                                         input logic [IDV_W-1:0] val);
        t_in_item it;
        it          = noise_item(OP_ID);
        it.id_index = idx;
        it.id_value = val;
        return it;
    endfunction

    function automatic t_in_item scan_item(input logic [SYMBOL_W-1:0] c, input logic rs);
        t_in_item it;
        it         = noise_item(OP_SCAN);
        it.symbol  = c;
        it.restart = rs;
        return it;
    endfunction

    function automatic logic [STATE_W-1:0] any_live_state();
        return live_states[$urandom_range(0, N_ST - 1)];
    endfunction

    function automatic logic [SYMBOL_W-1:0] any_live_sym();
        return live_syms[$urandom_range(0, N_COL - 1)];
    endfunction

    // Runs start inside the loaded id slots: 4064..4095 and 0..47
    function automatic logic [OFF_W-1:0] any_run_start();
        if ($urandom_range(0, 1) != 0) begin
            return OFF_W'($urandom_range(4064, 4095));
        end
        return OFF_W'($urandom_range(0, 47));
    endfunction

    function automatic logic [COUNT_W-1:0] any_run_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return COUNT_W'($urandom_range(0, 3));
        end
        if (r < 9) begin
            return COUNT_W'($urandom_range(0, 16));
        end
        return COUNT_W'($urandom_range(17, 31));
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        track_item(it);
        burst_left--;
    endtask

    task automatic hold_until_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_matches.size() != 0);
    endtask

    task automatic test_load_automaton();
        live_states[0] = '0;
        live_states[1] = '1;
        for (int i = 2; i < N_ST; i++) begin
            live_states[i] = STATE_W'($urandom_range(1, STATE_LIMIT - 2));
        end
        live_syms[0] = '0;
        live_syms[1] = '1;
        for (int i = 2; i < N_COL; i++) begin
            live_syms[i] = SYMBOL_W'($urandom_range(1, 254));
        end
        for (int i = 0; i < 64; i++) begin
            send_item(id_item(IDX_W'(i), IDV_W'($urandom)));
        end
        for (int i = 4064; i < 4096; i++) begin
            send_item(id_item(IDX_W'(i), IDV_W'($urandom)));
        end
        for (int i = 0; i < N_ST; i++) begin
            send_item(outs_item(live_states[i], any_run_start(), any_run_len()));
        end
        for (int i = 0; i < N_ST; i++) begin
            for (int j = 0; j < N_COL; j++) begin
                send_item(trans_item(live_states[i], live_syms[j], any_live_state()));
            end
        end
    endtask

    task automatic test_directed_edges();
        t_in_item ld;
        send_item(trans_item('0, '1, '1));
        send_item(trans_item('1, '0, '0));
        send_item(id_item('1, '1));
        send_item(id_item('0, '0));
        send_item(outs_item('0, '0, '0));
        // oversize run that also wraps the id store
        send_item(outs_item('1, OFF_W'(4088), COUNT_W'(31)));
        send_item(scan_item('1, 1'b1));
        send_item(scan_item('0, 1'b0));
        ld         = id_item(IDX_W'(100), '0);
        ld.restart = 1'b1;
        send_item(ld);
        send_item(scan_item('1, 1'b0));
        send_item(outs_item('1, '1, COUNT_W'(MATCH_MAX)));
        send_item(scan_item('0, 1'b0));
        send_item(scan_item('1, 1'b1));
        send_item(outs_item('1, OFF_W'(4064), COUNT_W'(1)));
        send_item(scan_item('0, 1'b1));
        send_item(scan_item('1, 1'b0));
        send_item(outs_item('1, OFF_W'(47), COUNT_W'(17)));
        send_item(scan_item('0, 1'b0));
        send_item(scan_item('1, 1'b0));
        hold_until_drained();
    endtask

    task automatic test_random_text();
        int                 pick;
        logic [STATE_W-1:0] s;
        for (int n = 0; n < ITEMS; n++) begin
            if (n == ITEMS / 2) begin
                hold_until_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_item(scan_item(any_live_sym(), $urandom_range(0, 19) == 0));
            end else if (pick < 80) begin
                send_item(trans_item(any_live_state(), any_live_sym(), any_live_state()));
            end else if (pick < 84) begin
                send_item(trans_item(STATE_W'($urandom), SYMBOL_W'($urandom),
                                     any_live_state()));
            end else if (pick < 92) begin
                s = ($urandom_range(0, 1) != 0) ? any_live_state() : STATE_W'($urandom);
                send_item(outs_item(s, any_run_start(), any_run_len()));
            end else begin
                send_item(id_item(IDX_W'($urandom), IDV_W'($urandom)));
            end
        end
        hold_until_drained();
    endtask

    // Receiver: short stall runs between longer open stretches
    always @(posedge clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (out_stall || $urandom_range(0, 2) == 0) begin
            out_stall <= 1'b0;
            rx_hold   <= $urandom_range(0, 40);
        end else begin
            out_stall <= 1'b1;
            rx_hold   <= $urandom_range(0, 7);
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected transaction: pos %0d id %h last %b",
                             out_item.end_position, out_item.match_id, out_item.last);
                end
            end else begin
                want = pending_matches.pop_front();
                if (out_item.end_position !== want.end_position ||
                    out_item.match_id !== want.match_id ||
                    out_item.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch: exp pos %0d id %h last %b, got pos %0d id %h last %b",
                                 want.end_position, want.match_id, want.last,
                                 out_item.end_position, out_item.match_id, out_item.last);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_load_automaton();
        test_directed_edges();
        test_random_text();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_matches.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### sim.f
rtl/aho_pkg.sv
rtl/aho_front.sv
rtl/aho_queue.sv
rtl/aho_back.sv
rtl/aho_corasick_flat_scan.sv
tb/tb_top.sv
